// ===== hdl/knn_pkg.sv =====
package knn_pkg;

    localparam int MaxTrain    = 1024;
    localparam int MaxFeatures = 16;
    localparam int MaxK        = 16;
    localparam int NumClasses  = 16;

    localparam int RowW   = 10;
    localparam int FeatW  = 4;
    localparam int LabelW = 5;
    localparam int ValW   = 16;
    localparam int DistW  = 37;
    localparam int AddrW  = RowW + FeatW;

    // Configuration register indexes
    localparam logic [1:0] RegNeighbours = 2'd0;
    localparam logic [1:0] RegFeatures   = 2'd1;
    localparam logic [1:0] RegTrain      = 2'd2;

    localparam logic OpLoad  = 1'b0;
    localparam logic OpQuery = 1'b1;

    typedef logic [DistW-1:0] dist_t;

endpackage

// ===== hdl/knn_classifier_top.sv =====
// k-nearest-neighbour classifier.
// Input stream s_axis: tdata carries op, row, feature_index, feature_value and
// class_label; tlast is query_last. Load transactions (op = 0) write one
// training feature and the row's label and are taken one per cycle while idle.
// Query transactions (op = 1) store one query feature; the one with tlast set
// starts a search and yields one result on m_axis (predicted_label,
// winning_votes). The search walks the stored rows through one shared
// subtract-and-square unit, one feature at a time, into a sorted list of
// the k nearest rows, then counts votes one neighbour per cycle and picks the
// winner one class per cycle. Each feature needs a registered store read and
// an accumulate step, each row a start and an insertion step, and then come
// the vote and pick steps. s_axis_tready is low during the search.
// The result waits in an output register until taken; the next transaction
// is accepted from the cycle after the result has gone. Reset returns the block
// to idle with registers at k = 1, four features and 1024 rows; the stores hold
// no defined values until written. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is idle,
// which the block itself does not enforce.
module knn_classifier_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[0], row[10:1], feature_index[14:11], feature_value[30:15],
    // class_label[35:31], zero fill[39:36]
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // predicted_label[4:0], winning_votes[9:5], zero fill[15:10]
    output logic [15:0] m_axis_tdata
);
    import knn_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ROW, ST_RD, ST_ACC, ST_INS, ST_VOTE, ST_PICK, ST_OUT
    } state_t;

    // Configuration registers
    logic [4:0]  nk_reg;
    logic [4:0]  nf_reg;
    logic [10:0] nt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nk_reg <= 5'd1;
            nf_reg <= 5'd4;
            nt_reg <= 11'd1024;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegNeighbours: nk_reg <= cfg_data[4:0];
                RegFeatures:   nf_reg <= cfg_data[4:0];
                RegTrain:      nt_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Clamped working values
    logic [4:0]  nk_c;
    logic [4:0]  nf_c;
    logic [10:0] nt_c;
    logic [4:0]  k_eff;

    always_comb
    begin
        nk_c = (nk_reg == 5'd0) ? 5'd1 : ((nk_reg > 5'd16) ? 5'd16 : nk_reg);
        nf_c = (nf_reg == 5'd0) ? 5'd1 : ((nf_reg > 5'd16) ? 5'd16 : nf_reg);
        nt_c = (nt_reg == 11'd0) ? 11'd1 : ((nt_reg > 11'd1024) ? 11'd1024 : nt_reg);
        k_eff = ({6'd0, nk_c} > nt_c) ? nt_c[4:0] : nk_c;
    end

    // Input field unpacking
    logic              in_op;
    logic [RowW-1:0]   in_row;
    logic [FeatW-1:0]  in_fi;
    logic [ValW-1:0]   in_val;
    logic [LabelW-1:0] in_lab;
    logic              in_acc;

    assign in_op  = s_axis_tdata[0];
    assign in_row = s_axis_tdata[10:1];
    assign in_fi  = s_axis_tdata[14:11];
    assign in_val = s_axis_tdata[30:15];
    assign in_lab = s_axis_tdata[35:31];
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Stores
    logic [ValW-1:0]   feat_mem [MaxTrain*MaxFeatures];
    logic [LabelW-1:0] label_mem [MaxTrain];
    logic [ValW-1:0]   query_mem [MaxFeatures];
    logic [ValW-1:0]   feat_rd_reg;
    logic [LabelW-1:0] label_rd_reg;

    // Sequencer state
    state_t            state_reg;
    logic [10:0]       row_reg;
    logic [4:0]        f_reg;
    dist_t             acc_reg;
    logic [4:0]        kept_reg;
    dist_t             nd_reg [MaxK];
    logic [LabelW-1:0] nl_reg [MaxK];
    logic [4:0]        votes_reg [NumClasses];
    logic [4:0]        idx_reg;
    logic [4:0]        best_lab_reg;
    logic [4:0]        best_votes_reg;
    logic [9:0]        out_reg;

    // Shared unit: one subtract and square per cycle
    logic signed [16:0] diff;
    logic [16:0]        adiff;
    logic [33:0]        sq;

    always_comb
    begin
        diff  = $signed({feat_rd_reg[15], feat_rd_reg}) -
                $signed({query_mem[f_reg[3:0]][15], query_mem[f_reg[3:0]]});
        adiff = diff[16] ? 17'(-diff) : 17'(diff);
        sq    = 34'(adiff) * 34'(adiff);
    end

    // Insertion position into the sorted list
    logic [MaxK-1:0] less;
    logic [4:0]      pos;

    always_comb
    begin
        for (int i = 0; i < MaxK; i++)
        begin
            less[i] = (5'(i) < kept_reg) && (acc_reg < nd_reg[i]);
        end
        pos = kept_reg;
        for (int i = MaxK - 1; i >= 0; i--)
        begin
            if (less[i])
            begin
                pos = 5'(i);
            end
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {6'd0, out_reg};

    // Stores are written by load and query transactions, read by the search
    always_ff @(posedge clk)
    begin
        if (in_acc && in_op == OpLoad)
        begin
            feat_mem[{in_row, in_fi}] <= in_val;
            label_mem[in_row] <= in_lab;
        end
        feat_rd_reg  <= feat_mem[{row_reg[RowW-1:0], f_reg[3:0]}];
        label_rd_reg <= label_mem[row_reg[RowW-1:0]];
        if (in_acc && in_op == OpQuery)
        begin
            query_mem[in_fi] <= in_val;
        end
    end

    // Search sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_reg        <= '0;
            f_reg          <= '0;
            acc_reg        <= '0;
            kept_reg       <= '0;
            idx_reg        <= '0;
            best_lab_reg   <= 5'd1;
            best_votes_reg <= '0;
            out_reg        <= '0;
            for (int i = 0; i < MaxK; i++)
            begin
                nd_reg[i] <= '1;
                nl_reg[i] <= '0;
            end
            for (int i = 0; i < NumClasses; i++)
            begin
                votes_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && in_op == OpQuery && s_axis_tlast)
                    begin
                        row_reg  <= '0;
                        kept_reg <= '0;
                        state_reg <= ST_ROW;
                    end
                end
                // Start a row: read address settles, accumulator cleared
                ST_ROW:
                begin
                    f_reg     <= '0;
                    acc_reg   <= '0;
                    state_reg <= ST_RD;
                end
                ST_RD:
                begin
                    state_reg <= ST_ACC;
                end
                // Accumulate one feature term; the next feature is first read in ST_RD
                ST_ACC:
                begin
                    acc_reg <= acc_reg + DistW'(sq);
                    if (f_reg + 5'd1 == nf_c)
                    begin
                        state_reg <= ST_INS;
                    end
                    else
                    begin
                        f_reg     <= f_reg + 5'd1;
                        state_reg <= ST_RD;
                    end
                end
                // Sorted insertion of the finished row
                ST_INS:
                begin
                    if (pos < k_eff)
                    begin
                        for (int i = 1; i < MaxK; i++)
                        begin
                            if (5'(i) > pos)
                            begin
                                nd_reg[i] <= nd_reg[i-1];
                                nl_reg[i] <= nl_reg[i-1];
                            end
                        end
                        nd_reg[pos[3:0]] <= acc_reg;
                        nl_reg[pos[3:0]] <= label_rd_reg;
                        if (kept_reg < k_eff)
                        begin
                            kept_reg <= kept_reg + 5'd1;
                        end
                    end
                    if (row_reg + 11'd1 == nt_c)
                    begin
                        idx_reg   <= '0;
                        for (int i = 0; i < NumClasses; i++)
                        begin
                            votes_reg[i] <= '0;
                        end
                        state_reg <= ST_VOTE;
                    end
                    else
                    begin
                        row_reg   <= row_reg + 11'd1;
                        state_reg <= ST_ROW;
                    end
                end
                // Count one neighbour's vote per cycle
                ST_VOTE:
                begin
                    if (idx_reg == kept_reg)
                    begin
                        idx_reg        <= '0;
                        best_lab_reg   <= 5'd1;
                        best_votes_reg <= '0;
                        state_reg      <= ST_PICK;
                    end
                    else
                    begin
                        if (nl_reg[idx_reg[3:0]] != 5'd0 && nl_reg[idx_reg[3:0]] <= 5'd16)
                        begin
                            votes_reg[4'(nl_reg[idx_reg[3:0]] - 5'd1)] <=
                                votes_reg[4'(nl_reg[idx_reg[3:0]] - 5'd1)] + 5'd1;
                        end
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                // Pick the winner one class per cycle, smallest label on ties
                ST_PICK:
                begin
                    if (idx_reg == 5'(NumClasses))
                    begin
                        out_reg   <= {best_votes_reg, best_lab_reg};
                        for (int i = 0; i < MaxK; i++)
                        begin
                            nd_reg[i] <= '1;
                            nl_reg[i] <= '0;
                        end
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        if (votes_reg[idx_reg[3:0]] > best_votes_reg)
                        begin
                            best_votes_reg <= votes_reg[idx_reg[3:0]];
                            best_lab_reg   <= idx_reg + 5'd1;
                        end
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
